### rtl/s256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package s256_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
	} front_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} core_state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam int FIFO_DEPTH = 4;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

### rtl/s256_front.sv
`timescale 1ns / 1ps
`default_nettype none
module s256_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	output logic                      full,
	input  wire                       mode,
	input  wire [7:0]                 data_byte,
	output s256_pkg::front_item_t     item,
	output logic                      item_valid,
	input  wire                       item_take
);
	import s256_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	front_item_t mem_q [FIFO_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = item_take && item_valid;
	assign item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= '{mode: mode, data: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

### rtl/s256_back.sv
`timescale 1ns / 1ps
`default_nettype none
module s256_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  s256_pkg::front_item_t     item,
	input  wire                       item_valid,
	output logic                      item_take,
	output logic                      empty,
	input  wire                       pop,
	output logic [31:0]               digest_word,
	output logic [2:0]                word_index,
	output logic                      last_word
);
	import s256_pkg::*;

	core_state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] count_q;
	logic [63:0] bits_q;
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [2:0]  emit_q;
	logic        padding_q;
	logic        pad_first_q;
	logic        len_stage_q;
	logic [2:0]  len_idx_q;

	logic        byte_we;
	logic [7:0]  byte_val;
	logic [31:0] w_new, t1, t2, sg0, sg1;
	logic [31:0] wt;

	// schedule window is a 16-word shift line; bytes shift into it during loading
	always_comb begin
		sg0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		sg1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + sg0 + w_q[9] + sg1;
		wt = (round_q < 6'd16) ? w_q[0] : w_new;
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[round_q] + wt;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		item_take = 1'b0;
		byte_we = 1'b0;
		byte_val = item.data;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_take = 1'b1;
					if (!item.mode) begin
						byte_we = 1'b1;
						if (fill_q == 6'd63) state_d = ST_ROUND;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				byte_we = 1'b1;
				if (pad_first_q) byte_val = PAD_BYTE;
				else if (len_stage_q) byte_val = bits_q[63:56];
				else byte_val = 8'h00;
				if (fill_q == 6'd63) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == 6'd63) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (padding_q && !(len_stage_q && len_idx_q == 3'd0 && fill_q == 6'd0
					&& !pad_first_q))
					state_d = ST_PAD;
				else if (padding_q)
					state_d = ST_EMIT;
				else
					state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (pop && emit_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign empty = (state_q != ST_EMIT);
	assign digest_word = h_q[emit_q];
	assign word_index = emit_q;
	assign last_word = (emit_q == 3'd7);

	always_ff @(posedge clk) begin
		if (byte_we) begin
			if (fill_q[1:0] == 2'd0) begin
				w_q[15] <= {byte_val, 24'h0};
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			end else begin
				w_q[15] <= w_q[15] | (32'(byte_val) << (8 * (3 - int'(fill_q[1:0]))));
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
		if (state_q == ST_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
			count_q <= '0;
			bits_q <= '0;
			fill_q <= '0;
			round_q <= '0;
			emit_q <= '0;
			padding_q <= 1'b0;
			pad_first_q <= 1'b0;
			len_stage_q <= 1'b0;
			len_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (byte_we) fill_q <= fill_q + 6'd1;
			if (state_q == ST_IDLE && item_valid) begin
				if (!item.mode) begin
					count_q <= count_q + 64'd1;
				end else begin
					padding_q <= 1'b1;
					pad_first_q <= 1'b1;
					len_stage_q <= 1'b0;
					len_idx_q <= '0;
					bits_q <= {count_q[60:0], 3'b000};
				end
			end
			if (state_q == ST_PAD) begin
				pad_first_q <= 1'b0;
				if (len_stage_q) begin
					bits_q <= {bits_q[55:0], 8'h00};
					len_idx_q <= len_idx_q + 3'd1;
				end
				if (fill_q == LEN_OFFSET - 6'd1) len_stage_q <= 1'b1;
			end
			if (state_q == ST_ROUND) round_q <= round_q + 6'd1;
			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				if (state_d == ST_EMIT) emit_q <= '0;
			end
			if (state_q == ST_EMIT && pop) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
					count_q <= '0;
					fill_q <= '0;
					padding_q <= 1'b0;
					len_stage_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// byte-serial sha-256: one byte enters per transfer through a four-entry queue; a full block
// is loaded byte by byte, then runs its 64 rounds (one round per cycle) and a fold step; a finish
// item pads through one or two blocks at one byte per cycle and then offers the eight digest
// words, word 0 first, one per pop transfer
module sha256_stream_hasher_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire        mode,
	input  wire [7:0]  data_byte,
	output logic       empty,
	input  wire        pop,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic       last_word
);
	import s256_pkg::*;

	front_item_t item;
	logic item_valid, item_take;

	s256_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.data_byte(data_byte), .item(item), .item_valid(item_valid), .item_take(item_take)
	);

	s256_back u_back (
		.clk(clk), .arst_n(arst_n), .item(item), .item_valid(item_valid),
		.item_take(item_take), .empty(empty), .pop(pop), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);
endmodule
`default_nettype wire

### dv/sha256_digest_checker.sv
`timescale 1ns / 1ps
module sha256_digest_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire        full,
	input  wire        mode,
	input  wire [7:0]  data_byte,
	input  wire        empty,
	input  wire        pop,
	input  wire [31:0] digest_word,
	input  wire [2:0]  word_index,
	input  wire        last_word,
	output int         fail_count,
	output int         words_pending,
	output int         digests_seen
);
	import s256_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	logic [31:0] chain [8];
	logic [7:0]  block [64];
	logic [5:0]  fill;
	logic [63:0] byte_count;
	digest_entry_t digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {block[4*r], block[4*r+1], block[4*r+2], block[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = w[r-16] + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
				+ w[r-7] + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
		for (int j = 0; j < 8; j++)
			v[j] = chain[j];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			chain[j] += v[j];
	endtask

	task automatic absorb(input logic [7:0] b);
		block[fill] = b;
		fill++;
		if (fill == 0)
			compress();
	endtask

	task automatic restart();
		for (int j = 0; j < 8; j++)
			chain[j] = H_INIT[j];
		fill = 0;
		byte_count = 0;
	endtask

	task automatic finish_message();
		logic [63:0] bits;
		bits = byte_count << 3;
		absorb(PAD_BYTE);
		while (fill != LEN_OFFSET)
			absorb(8'h00);
		for (int i = 0; i < 8; i++)
			absorb(bits[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++)
			digest_q.push_back('{chain[i], 3'(i), i == 7});
		restart();
	endtask

	digest_entry_t exp_e;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart();
			digest_q.delete();
			fail_count <= 0;
			digests_seen <= 0;
		end else begin
			if (push && !full) begin
				if (mode)
					finish_message();
				else begin
					absorb(data_byte);
					byte_count++;
				end
			end
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, digest_word);
					fail_count <= fail_count + 1;
				end else begin
					exp_e = digest_q.pop_front();
					if (exp_e.word !== digest_word || exp_e.index !== word_index
						|| exp_e.last !== last_word) begin
						$display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
							exp_e.word, exp_e.index, exp_e.last,
							digest_word, word_index, last_word);
						fail_count <= fail_count + 1;
					end
					if (last_word)
						digests_seen <= digests_seen + 1;
				end
			end
		end
	end

	assign words_pending = digest_q.size();
endmodule

### dv/tb_sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_core;
	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic mode = 0;
	logic [7:0] data_byte = 0;
	logic pop = 0;
	wire full, empty, last_word;
	wire [31:0] digest_word;
	wire [2:0] word_index;
	int fail_count, words_pending, digests_seen;
	int idle_cycles = 0;
	int sent = 0;
	int finishes = 0;
	int len_list [4] = '{55, 56, 63, 64};

	always #4 clk = ~clk;

	sha256_stream_hasher_core dut (.*);

	sha256_digest_checker checker_i (.*);

	// receiver pops steadily in one part of each repeating window and stalls at random in the rest
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase % 600 < 150)
			pop <= 1;
		else
			pop <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (arst_n && !((push && !full) || (pop && !empty)))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
		if (idle_cycles > 5000) begin
			$display("tb_sha256_stream_hasher_core NOT OK");
			$finish;
		end
	end

	task automatic send(input logic m, input logic [7:0] b);
		push <= 1;
		mode <= m;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		if (m)
			finishes++;
	endtask

	task automatic gap();
		if ($urandom_range(0, 2) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic message(input int len);
		for (int i = 0; i < len; i++) begin
			send(0, 8'($urandom));
			gap();
		end
		send(1, 8'($urandom));
		gap();
	endtask

	int len;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty message, then a four-byte message; edge lengths around the padding boundary follow later
		send(1, 8'hff);
		send(0, 8'h00); send(0, 8'hff); send(0, 8'h55); send(0, 8'haa); send(1, 8'h00);
		push <= 0;
		while (words_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		foreach (len_list[k])
			message(len_list[k]);
		while (sent < 270) begin
			len = $urandom_range(0, 8);
			message(len);
		end
		push <= 0;
		while (words_pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("run covered %0d items, %0d finish items, %0d digests checked",
			sent, finishes, digests_seen);
		if (fail_count == 0 && words_pending == 0)
			$display("tb_sha256_stream_hasher_core OK");
		else
			$display("tb_sha256_stream_hasher_core NOT OK");
		$finish;
	end
endmodule

### files.f
rtl/s256_pkg.sv
rtl/s256_front.sv
rtl/s256_back.sv
rtl/sha256_stream_hasher_core.sv
dv/sha256_digest_checker.sv
dv/tb_sha256_stream_hasher_core.sv
